// File: hdl/mcf_pkg.sv
`default_nettype none
package mcf_pkg;

    localparam int MAX_NODES_DEF = 128;

    localparam int COST_W  = 31;
    localparam int RES_W   = 33;
    localparam int DIST_W  = 64;
    localparam int FLOW_W  = 32;
    localparam int TCOST_W = 63;

    localparam logic [DIST_W-1:0]  DIST_INF = 64'd99999999999999;
    localparam logic [TCOST_W-1:0] COST_TOP = {TCOST_W{1'b1}};

    // register indexes on the configuration port (byte address / 4)
    localparam logic [1:0] REG_NODE_COUNT    = 2'd0;
    localparam logic [1:0] REG_REQUIRED_FLOW = 2'd1;
    localparam logic [1:0] REG_EDGE_CAPACITY = 2'd2;

    typedef struct packed {
        logic cost_we;
        logic res_we;
    } mat_we_t;

endpackage
`default_nettype wire

// File: hdl/min_cost_flow_bellman_ford.sv
`default_nettype none
// Min-cost flow solver. Add transactions (tuser 0) load an undirected edge
// into the cost and residual matrices, writing one direction and then the
// other; an edge with an endpoint of zero or above MAX_NODES is dropped. A
// solve transaction (tuser 1) gives every loaded edge the configured capacity
// in both directions, then runs rounds of Bellman-Ford and path augmentation
// from the first to the last of n nodes (node_count clamped to 2..MAX_NODES).
// A round does table init, n-1 passes over all rows (rows of unreached nodes
// are not scanned), a bottleneck walk along the path, an update walk and the
// cost update; it is bound by the single read port of the matrix memories.
// One result transaction follows the last round, then both matrices are
// zeroed while no input is taken. The same clearing pass runs after reset.
// Node count, required flow and capacity must not change mid-solve.
module min_cost_flow_bellman_ford #(
    parameter int MAX_NODES = mcf_pkg::MAX_NODES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [7:0] node_a, [15:8] node_b, [45:16] edge_cost, [47:46] zero
    input  wire logic [47:0] s_tdata,
    // [0] action
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [31:0] flow_reached, [32] feasible, [95:33] total_cost
    output logic      [95:0] m_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    localparam int NW  = $clog2(MAX_NODES);
    localparam int AW  = 2 * NW;
    localparam int NCW = NW + 1;
    localparam int CW  = mcf_pkg::COST_W;
    localparam int RW  = mcf_pkg::RES_W;
    localparam int DW  = mcf_pkg::DIST_W;
    localparam int FW  = mcf_pkg::FLOW_W;
    localparam int TW  = mcf_pkg::TCOST_W;

    typedef enum logic [23:0] {
        ST_CLEAR   = 24'h000001,
        ST_IDLE    = 24'h000002,
        ST_ADD2    = 24'h000004,
        ST_CAP     = 24'h000008,
        ST_CAP_END = 24'h000010,
        ST_INIT    = 24'h000020,
        ST_HEAD    = 24'h000040,
        ST_LATCH   = 24'h000080,
        ST_SCAN    = 24'h000100,
        ST_DRAIN   = 24'h000200,
        ST_W1_REQ  = 24'h000400,
        ST_W1_PAR  = 24'h000800,
        ST_W1_RES  = 24'h001000,
        ST_W2_REQ  = 24'h002000,
        ST_W2_PAR  = 24'h004000,
        ST_W2_UV   = 24'h008000,
        ST_W2_VU   = 24'h010000,
        ST_M_RD    = 24'h020000,
        ST_M_MAG   = 24'h040000,
        ST_M_LO    = 24'h080000,
        ST_M_HI    = 24'h100000,
        ST_M_SUM   = 24'h200000,
        ST_M_ACC   = 24'h400000,
        ST_FINISH  = 24'h800000
    } state_t;

    state_t st_reg, st_next;

    // configuration
    logic [7:0]  nc_reg;
    logic [31:0] req_reg;
    logic [31:0] cap_reg;
    logic        cfg_wr;

    // counters and walk registers
    logic [AW-1:0] clr_cnt_reg;
    logic [NW-1:0] u_reg, j_reg, v_reg, pass_reg, steps_reg;
    logic          s1_v_reg;
    logic [AW-1:0] s1_addr_reg;
    logic signed [DW-1:0] du_reg;
    logic [RW-1:0] bott_reg;
    logic [FW-1:0] push_reg;
    logic [CW-1:0] cost_uv_reg;
    logic [DW-1:0] mag_reg;
    logic          neg_reg;
    logic [63:0]   plo_reg, phi_reg;
    logic [TW-1:0] term_reg;
    logic [FW-1:0] flow_reg;
    logic [TW-1:0] tcost_reg;
    logic [29:0]   ecost_reg;

    // result register
    logic          m_tvalid_reg;
    logic [95:0]   m_tdata_reg;

    // input fields
    logic [7:0]  in_node_a, in_node_b;
    logic [29:0] in_edge_cost;
    logic        add_ok;
    logic [NW-1:0] ia, ib;

    logic [NCW-1:0] n_eff;
    logic [NW-1:0]  nm1;
    logic [FW-1:0]  need, f_calc;
    logic           last_row, last_pass;
    logic           in_acc, out_load;

    // matrix memory ports
    mcf_pkg::mat_we_t mat_we;
    logic [AW-1:0] mat_raddr, cost_waddr, res_waddr;
    logic [CW-1:0] cost_wd, cost_rd;
    logic [RW-1:0] res_wd, res_rd;

    // distance and parent tables
    logic [DW-1:0] dist_mem [MAX_NODES];
    logic [NW:0]   par_mem  [MAX_NODES];
    logic [DW-1:0] dist_rd;
    logic [NW:0]   par_rd;
    logic          dp_we;
    logic [NW-1:0] dp_waddr, dist_raddr;
    logic [DW-1:0] dist_wd;
    logic [NW:0]   par_wd;
    logic [NW-1:0] parent_u;

    logic signed [DW-1:0] cand;
    logic                 relax_hit;
    logic [95:0]          full_prod;

    assign in_node_a    = s_tdata[7:0];
    assign in_node_b    = s_tdata[15:8];
    assign in_edge_cost = s_tdata[45:16];
    assign add_ok = (in_node_a != 8'd0) && (in_node_b != 8'd0)
                 && (32'(in_node_a) <= 32'(MAX_NODES))
                 && (32'(in_node_b) <= 32'(MAX_NODES));
    assign ia = NW'(32'(in_node_a) - 32'd1);
    assign ib = NW'(32'(in_node_b) - 32'd1);

    always_comb begin
        if (32'(nc_reg) < 32'd2) begin
            n_eff = NCW'(2);
        end else if (32'(nc_reg) > 32'(MAX_NODES)) begin
            n_eff = NCW'(MAX_NODES);
        end else begin
            n_eff = NCW'(nc_reg);
        end
    end
    assign nm1 = NW'(n_eff - NCW'(1));

    assign need   = req_reg - flow_reg;
    assign f_calc = (bott_reg < {1'b0, need}) ? bott_reg[FW-1:0] : need;

    assign last_row  = (u_reg == nm1);
    assign last_pass = (pass_reg == nm1 - NW'(1));

    assign s_tready = (st_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_load = (st_reg == ST_FINISH) && (!m_tvalid_reg || m_tready);

    assign parent_u = par_rd[NW-1:0];

    // relaxation of the entry read in the previous cycle
    assign cand = du_reg + {{(DW - CW){cost_rd[CW-1]}}, cost_rd};
    assign relax_hit = s1_v_reg && (res_rd != '0) && (cand < $signed(dist_rd));

    assign full_prod = {phi_reg, 32'd0} + {32'd0, plo_reg};

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[3:2])
            mcf_pkg::REG_NODE_COUNT:    prdata = {24'd0, nc_reg};
            mcf_pkg::REG_REQUIRED_FLOW: prdata = req_reg;
            mcf_pkg::REG_EDGE_CAPACITY: prdata = cap_reg;
            default:                    prdata = 32'd0;
        endcase
    end

    // next state
    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == '1) st_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_acc) begin
                    if (s_tuser) begin
                        st_next = ST_CAP;
                    end else if (add_ok) begin
                        st_next = ST_ADD2;
                    end
                end
            end
            ST_ADD2:    st_next = ST_IDLE;
            ST_CAP: begin
                if (last_row && j_reg == nm1) st_next = ST_CAP_END;
            end
            ST_CAP_END: st_next = ST_INIT;
            ST_INIT: begin
                if (last_row) st_next = ST_HEAD;
            end
            ST_HEAD:    st_next = ST_LATCH;
            ST_LATCH: begin
                if (dist_rd != mcf_pkg::DIST_INF) begin
                    st_next = ST_SCAN;
                end else if (last_row && last_pass) begin
                    st_next = ST_W1_REQ;
                end else begin
                    st_next = ST_HEAD;
                end
            end
            ST_SCAN: begin
                if (j_reg == nm1) st_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                st_next = (last_row && last_pass) ? ST_W1_REQ : ST_HEAD;
            end
            ST_W1_REQ: begin
                if (v_reg != '0) begin
                    st_next = ST_W1_PAR;
                end else begin
                    st_next = (f_calc == '0) ? ST_FINISH : ST_W2_REQ;
                end
            end
            ST_W1_PAR: begin
                st_next = (!par_rd[NW] || steps_reg >= nm1) ? ST_FINISH : ST_W1_RES;
            end
            ST_W1_RES:  st_next = ST_W1_REQ;
            ST_W2_REQ:  st_next = (v_reg == '0) ? ST_M_RD : ST_W2_PAR;
            ST_W2_PAR:  st_next = ST_W2_UV;
            ST_W2_UV:   st_next = ST_W2_VU;
            ST_W2_VU:   st_next = ST_W2_REQ;
            ST_M_RD:    st_next = ST_M_MAG;
            ST_M_MAG:   st_next = ST_M_LO;
            ST_M_LO:    st_next = ST_M_HI;
            ST_M_HI:    st_next = ST_M_SUM;
            ST_M_SUM:   st_next = ST_M_ACC;
            ST_M_ACC:   st_next = ST_INIT;
            ST_FINISH: begin
                if (out_load) st_next = ST_CLEAR;
            end
            default:    st_next = ST_CLEAR;
        endcase
    end

    // matrix memory access
    always_comb begin
        mat_we     = '0;
        mat_raddr  = {u_reg, j_reg};
        cost_waddr = {u_reg, v_reg};
        res_waddr  = {u_reg, v_reg};
        cost_wd    = '0;
        res_wd     = '0;
        unique case (st_reg)
            ST_CLEAR: begin
                mat_we     = '{cost_we: 1'b1, res_we: 1'b1};
                cost_waddr = clr_cnt_reg;
                res_waddr  = clr_cnt_reg;
            end
            ST_IDLE: begin
                if (in_acc && !s_tuser && add_ok) begin
                    mat_we     = '{cost_we: 1'b1, res_we: 1'b1};
                    cost_waddr = {ia, ib};
                    res_waddr  = {ia, ib};
                    cost_wd    = {1'b0, in_edge_cost};
                    res_wd     = RW'(1);
                end
            end
            ST_ADD2: begin
                mat_we     = '{cost_we: 1'b1, res_we: 1'b1};
                cost_waddr = {v_reg, u_reg};
                res_waddr  = {v_reg, u_reg};
                cost_wd    = {1'b0, ecost_reg};
                res_wd     = RW'(1);
            end
            ST_CAP, ST_CAP_END: begin
                mat_we.res_we = s1_v_reg && (res_rd != '0);
                res_waddr     = s1_addr_reg;
                res_wd        = {1'b0, cap_reg};
            end
            ST_W1_PAR, ST_W2_PAR: begin
                mat_raddr = {parent_u, v_reg};
            end
            ST_W2_UV: begin
                mat_raddr     = {v_reg, u_reg};
                mat_we.res_we = 1'b1;
                res_waddr     = {u_reg, v_reg};
                res_wd        = res_rd - {1'b0, push_reg};
            end
            ST_W2_VU: begin
                mat_we        = '{cost_we: 1'b1, res_we: 1'b1};
                res_waddr     = {v_reg, u_reg};
                res_wd        = res_rd + {1'b0, push_reg};
                // flip the sign on the backward entry when forward cost is positive, else on the forward entry
                if ($signed(cost_uv_reg) > 0) begin
                    cost_waddr = {v_reg, u_reg};
                    cost_wd    = -cost_rd;
                end else begin
                    cost_waddr = {u_reg, v_reg};
                    cost_wd    = -cost_uv_reg;
                end
            end
            default: begin
                mat_we = '0;
            end
        endcase
    end

    mcf_mat_mem #(
        .ADDR_W (AW)
    ) u_mat (
        .aclk       (aclk),
        .raddr      (mat_raddr),
        .we         (mat_we),
        .cost_waddr (cost_waddr),
        .cost_wdata (cost_wd),
        .res_waddr  (res_waddr),
        .res_wdata  (res_wd),
        .cost_rdata (cost_rd),
        .res_rdata  (res_rd)
    );

    // distance and parent table access
    always_comb begin
        dp_we      = 1'b0;
        dp_waddr   = s1_addr_reg[NW-1:0];
        dist_wd    = cand;
        par_wd     = {1'b1, u_reg};
        dist_raddr = u_reg;
        if (st_reg == ST_INIT) begin
            dp_we    = 1'b1;
            dp_waddr = u_reg;
            dist_wd  = (u_reg == '0) ? '0 : mcf_pkg::DIST_INF;
            par_wd   = '0;
        end else if (st_reg == ST_SCAN || st_reg == ST_DRAIN) begin
            dp_we = relax_hit;
        end
        if (st_reg == ST_SCAN) begin
            dist_raddr = j_reg;
        end else if (st_reg == ST_M_RD) begin
            dist_raddr = nm1;
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_we) begin
            dist_mem[dp_waddr] <= dist_wd;
            par_mem[dp_waddr]  <= par_wd;
        end
        dist_rd <= dist_mem[dist_raddr];
        par_rd  <= par_mem[v_reg];
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            s1_v_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            nc_reg       <= 8'd2;
            req_reg      <= 32'd0;
            cap_reg      <= 32'd1;
            flow_reg     <= '0;
            tcost_reg    <= '0;
        end else begin
            st_reg   <= st_next;
            s1_v_reg <= (st_reg == ST_CAP) || (st_reg == ST_SCAN);

            if (cfg_wr) begin
                case (paddr[3:2])
                    mcf_pkg::REG_NODE_COUNT:    nc_reg  <= pwdata[7:0];
                    mcf_pkg::REG_REQUIRED_FLOW: req_reg <= pwdata;
                    mcf_pkg::REG_EDGE_CAPACITY: cap_reg <= pwdata;
                    default: ;
                endcase
            end

            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            if (st_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end else if (st_reg == ST_FINISH) begin
                clr_cnt_reg <= '0;
            end

            if (st_reg == ST_IDLE && in_acc && s_tuser) begin
                flow_reg  <= '0;
                tcost_reg <= '0;
            end else if (st_reg == ST_M_ACC) begin
                flow_reg <= flow_reg + push_reg;
                if (neg_reg) begin
                    tcost_reg <= (term_reg >= tcost_reg) ? '0 : tcost_reg - term_reg;
                end else if (64'(tcost_reg) + 64'(term_reg) > 64'(mcf_pkg::COST_TOP)) begin
                    tcost_reg <= mcf_pkg::COST_TOP;
                end else begin
                    tcost_reg <= tcost_reg + term_reg;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        s1_addr_reg <= {u_reg, j_reg};
        case (st_reg)
            ST_IDLE: begin
                u_reg     <= s_tuser ? '0 : ia;
                v_reg     <= ib;
                j_reg     <= '0;
                ecost_reg <= in_edge_cost;
            end
            ST_CAP: begin
                if (j_reg == nm1) begin
                    j_reg <= '0;
                    u_reg <= u_reg + NW'(1);
                end else begin
                    j_reg <= j_reg + NW'(1);
                end
            end
            ST_CAP_END: u_reg <= '0;
            ST_INIT: begin
                if (last_row) begin
                    u_reg    <= '0;
                    pass_reg <= '0;
                end else begin
                    u_reg <= u_reg + NW'(1);
                end
            end
            ST_LATCH, ST_DRAIN: begin
                du_reg <= $signed(dist_rd);
                j_reg  <= '0;
                if (st_reg == ST_DRAIN || dist_rd == mcf_pkg::DIST_INF) begin
                    if (!last_row) begin
                        u_reg <= u_reg + NW'(1);
                    end else if (last_pass) begin
                        v_reg     <= nm1;
                        steps_reg <= '0;
                        bott_reg  <= '1;
                    end else begin
                        u_reg    <= '0;
                        pass_reg <= pass_reg + NW'(1);
                    end
                end
            end
            ST_SCAN:   j_reg <= j_reg + NW'(1);
            ST_W1_REQ: begin
                if (v_reg == '0) begin
                    push_reg <= f_calc;
                    v_reg    <= nm1;
                end
            end
            ST_W1_PAR: u_reg <= parent_u;
            ST_W1_RES: begin
                if (res_rd < bott_reg) bott_reg <= res_rd;
                v_reg     <= u_reg;
                steps_reg <= steps_reg + NW'(1);
            end
            ST_W2_PAR: u_reg <= parent_u;
            ST_W2_UV:  cost_uv_reg <= cost_rd;
            ST_W2_VU:  v_reg <= u_reg;
            ST_M_MAG: begin
                neg_reg <= dist_rd[DW-1];
                mag_reg <= dist_rd[DW-1] ? (~dist_rd + DW'(1)) : dist_rd;
            end
            ST_M_LO:   plo_reg <= 64'(push_reg) * 64'(mag_reg[31:0]);
            ST_M_HI:   phi_reg <= 64'(push_reg) * 64'(mag_reg[63:32]);
            ST_M_SUM: begin
                term_reg <= (full_prod > 96'(mcf_pkg::COST_TOP))
                          ? mcf_pkg::COST_TOP : full_prod[TW-1:0];
            end
            ST_M_ACC:  u_reg <= '0;
            default: ;
        endcase
        if (out_load) begin
            m_tdata_reg <= {tcost_reg, (flow_reg >= req_reg), flow_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // the compare stage only runs behind a sweep that issued a read
    a_s1_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_v_reg |-> (st_reg == ST_SCAN || st_reg == ST_DRAIN
                   || st_reg == ST_CAP || st_reg == ST_CAP_END))
        else $error("compare stage valid outside a sweep");

    // augmentation never overshoots the demand
    a_flow_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_M_ACC) |=> (flow_reg <= req_reg))
        else $error("flow beyond required amount");

    // the update walk only starts with a nonzero push
    a_push_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_W1_REQ && st_next == ST_W2_REQ) |=> (push_reg != '0))
        else $error("update walk with zero push");
endmodule
`default_nettype wire

// File: hdl/mcf_mat_mem.sv
`default_nettype none
module mcf_mat_mem #(
    parameter int ADDR_W = 14
) (
    input  wire logic                          aclk,
    input  wire logic [ADDR_W-1:0]             raddr,
    input  wire mcf_pkg::mat_we_t              we,
    input  wire logic [ADDR_W-1:0]             cost_waddr,
    input  wire logic [mcf_pkg::COST_W-1:0]    cost_wdata,
    input  wire logic [ADDR_W-1:0]             res_waddr,
    input  wire logic [mcf_pkg::RES_W-1:0]     res_wdata,
    output logic      [mcf_pkg::COST_W-1:0]    cost_rdata,
    output logic      [mcf_pkg::RES_W-1:0]     res_rdata
);
    localparam int DEPTH = 1 << ADDR_W;

    logic [mcf_pkg::COST_W-1:0] cost_mem [DEPTH];
    logic [mcf_pkg::RES_W-1:0]  res_mem  [DEPTH];
    logic [mcf_pkg::COST_W-1:0] cost_rd_reg;
    logic [mcf_pkg::RES_W-1:0]  res_rd_reg;

    always_ff @(posedge aclk) begin
        if (we.cost_we) begin
            cost_mem[cost_waddr] <= cost_wdata;
        end
        cost_rd_reg <= cost_mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (we.res_we) begin
            res_mem[res_waddr] <= res_wdata;
        end
        res_rd_reg <= res_mem[raddr];
    end

    assign cost_rdata = cost_rd_reg;
    assign res_rdata  = res_rd_reg;
endmodule
`default_nettype wire

// File: dv/tb_min_cost_flow_bellman_ford.sv
`default_nettype none
module tb_min_cost_flow_bellman_ford;
    import mcf_pkg::*;

    localparam int  NODES     = MAX_NODES_DEF;
    localparam int  CELLS     = NODES * NODES;
    localparam int  LIMIT     = 8000000;
    localparam bit  ACT_ADD   = 1'b0;
    localparam bit  ACT_SOLVE = 1'b1;
    localparam longint unsigned TOTAL_TOP = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic [31:0] flow;
        logic        feasible;
        logic [62:0] cost;
    } flow_result_t;

    class flow_scoreboard;
        int              cost_m[CELLS];
        longint unsigned resid_m[CELLS];
        longint          dist_tab[NODES];
        int              parent[NODES];
        bit              parent_ok[NODES];
        logic [7:0]      node_count_r;
        logic [31:0]     required_r;
        logic [31:0]     capacity_r;
        flow_result_t    expected_flows[$];
        int              errors;

        function new();
            foreach (cost_m[i]) begin
                cost_m[i] = 0;
                resid_m[i] = 0;
            end
            node_count_r = 8'd2;
            required_r = 0;
            capacity_r = 1;
            errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_NODE_COUNT:    node_count_r = val[7:0];
                REG_REQUIRED_FLOW: required_r = val;
                REG_EDGE_CAPACITY: capacity_r = val;
                default: ;
            endcase
        endfunction

        function flow_result_t solve_min_cost_flow();
            int n, u, v, j, steps, pass;
            longint unsigned bott, need, f, mag, term, flow, total;
            longint du, cand, d;
            bit broken, over;
            flow_result_t r;
            n = node_count_r < 2 ? 2 : (node_count_r > NODES ? NODES : node_count_r);
            for (u = 0; u < n; u++)
                for (j = 0; j < n; j++)
                    if (resid_m[u*NODES+j] != 0) resid_m[u*NODES+j] = capacity_r;
            flow = 0;
            total = 0;
            while (1) begin
                for (u = 0; u < n; u++) begin
                    dist_tab[u] = longint'(DIST_INF);
                    parent_ok[u] = 0;
                    parent[u] = 0;
                end
                dist_tab[0] = 0;
                for (pass = 0; pass + 1 < n; pass++)
                    for (u = 0; u < n; u++) begin
                        du = dist_tab[u];
                        if (du == longint'(DIST_INF)) continue;
                        for (j = 0; j < n; j++) begin
                            if (resid_m[u*NODES+j] == 0) continue;
                            cand = du + longint'(cost_m[u*NODES+j]);
                            if (cand < dist_tab[j]) begin
                                dist_tab[j] = cand;
                                parent[j] = u;
                                parent_ok[j] = 1;
                            end
                        end
                    end
                // bottleneck walk back from the sink
                v = n - 1;
                steps = 0;
                broken = 0;
                bott = DIST_INF;
                while (v != 0 && !broken) begin
                    if (!parent_ok[v] || steps >= n - 1) begin
                        broken = 1;
                    end else begin
                        u = parent[v];
                        if (resid_m[u*NODES+v] < bott) bott = resid_m[u*NODES+v];
                        v = u;
                        steps++;
                    end
                end
                if (broken) break;
                need = longint'(required_r) - flow;
                f = bott < need ? bott : need;
                if (f == 0) break;
                v = n - 1;
                while (v != 0) begin
                    u = parent[v];
                    resid_m[u*NODES+v] -= f;
                    resid_m[v*NODES+u] += f;
                    if (cost_m[u*NODES+v] > 0) cost_m[v*NODES+u] = -cost_m[v*NODES+u];
                    else cost_m[u*NODES+v] = -cost_m[u*NODES+v];
                    v = u;
                end
                d = dist_tab[n-1];
                mag = d < 0 ? -d : d;
                over = mag > TOTAL_TOP / f;
                term = over ? TOTAL_TOP : f * mag;
                if (d >= 0) begin
                    if (over || term > TOTAL_TOP - total) total = TOTAL_TOP;
                    else total += term;
                end else begin
                    if (over || term >= total) total = 0;
                    else total -= term;
                end
                flow += f;
            end
            r.flow = flow[31:0];
            r.feasible = flow[31:0] >= required_r;
            r.cost = total[62:0];
            foreach (cost_m[i]) begin
                cost_m[i] = 0;
                resid_m[i] = 0;
            end
            return r;
        endfunction

        function void note_input(logic action, logic [7:0] a, logic [7:0] b, logic [29:0] c);
            int ia, ib;
            if (action == ACT_SOLVE) begin
                expected_flows.push_back(solve_min_cost_flow());
            end else if (a >= 1 && b >= 1 && a <= NODES && b <= NODES) begin
                ia = a - 1;
                ib = b - 1;
                cost_m[ia*NODES+ib] = c;
                cost_m[ib*NODES+ia] = c;
                resid_m[ia*NODES+ib] = 1;
                resid_m[ib*NODES+ia] = 1;
            end
        endfunction

        function void report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endfunction

        function void check_result(logic [95:0] d);
            flow_result_t e;
            if (expected_flows.size() == 0) begin
                report($sformatf("unexpected result %h", d));
                return;
            end
            e = expected_flows.pop_front();
            if (d[31:0] !== e.flow)
                report($sformatf("flow_reached %0d, want %0d", d[31:0], e.flow));
            if (d[32] !== e.feasible)
                report($sformatf("feasible %0b, want %0b", d[32], e.feasible));
            if (d[95:33] !== e.cost)
                report($sformatf("total_cost %0d, want %0d", d[95:33], e.cost));
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    flow_scoreboard sb;
    bit             quiet;
    int             cycles;
    int             cur_nodes;

    min_cost_flow_bellman_ford u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("tb_min_cost_flow_bellman_ford: errors");
            $finish;
        end
    end

    // transaction monitor
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_input(s_tuser, s_tdata[7:0], s_tdata[15:8], s_tdata[45:16]);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    always @(negedge aclk)
        m_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 26);

    task automatic send(input bit action, input int a, input int b, input logic [29:0] c);
        if (!quiet && $urandom_range(0, 99) < 26) begin
            s_tvalid = 0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tuser = action;
        s_tdata = {2'b00, c, b[7:0], a[7:0]};
        s_tvalid = 1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid = 0;
        while (sb.expected_flows.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        psel = 1;
        pwrite = 1;
        penable = 0;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge aclk);
        penable = 1;
        @(negedge aclk);
        psel = 0;
        penable = 0;
        sb.write_reg(idx, val);
    endtask

    task automatic setup(input logic [7:0] n, input logic [31:0] req, input logic [31:0] cap);
        drain();
        apb_write(REG_NODE_COUNT, 32'(n));
        apb_write(REG_REQUIRED_FLOW, req);
        apb_write(REG_EDGE_CAPACITY, cap);
        cur_nodes = n < 2 ? 2 : (n > NODES ? NODES : n);
    endtask

    function automatic int pick_node();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) return 0;
        if (r < 8) return $urandom_range(NODES + 1, 255);
        if (r < 12) return $urandom_range(1, NODES);
        return $urandom_range(1, cur_nodes);
    endfunction

    function automatic logic [29:0] pick_cost();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 30'($urandom_range(0, 20));
        if (r < 80) return 30'($urandom_range(0, 1000000000));
        return 30'($urandom);
    endfunction

    initial begin
        logic [7:0]  n;
        logic [31:0] req, cap;
        int          k;
        sb = new();
        quiet = 0;
        cycles = 0;
        cur_nodes = 2;
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tuser = 0;
        m_tready = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        repeat (4) @(negedge aclk);
        aresetn = 1;

        // empty graph with reset settings
        send(ACT_SOLVE, 0, 0, 0);
        // one edge, full capacity, ignored out-of-range endpoints
        setup(8'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(ACT_ADD, 1, 2, 30'd1000000000);
        send(ACT_ADD, 0, 2, 30'd5);
        send(ACT_ADD, 129, 1, 30'd5);
        send(ACT_ADD, 255, 255, 30'h3FFF_FFFF);
        send(ACT_SOLVE, 0, 0, 0);
        // long chain, cost saturates
        setup(8'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(ACT_ADD, 1, 2, 30'h3FFF_FFFF);
        send(ACT_ADD, 2, 3, 30'h3FFF_FFFF);
        send(ACT_ADD, 3, 4, 30'h3FFF_FFFF);
        send(ACT_SOLVE, 0, 0, 0);
        // zero capacity, node count below range
        setup(8'd0, 32'd5, 32'd0);
        send(ACT_ADD, 1, 2, 30'd3);
        send(ACT_SOLVE, 0, 0, 0);
        // node count above range, repeated edge, two paths
        setup(8'd255, 32'd2, 32'd2);
        send(ACT_ADD, 1, 128, 30'd7);
        send(ACT_ADD, 1, 2, 30'd3);
        send(ACT_ADD, 2, 128, 30'd3);
        send(ACT_ADD, 128, 1, 30'd1);
        send(ACT_SOLVE, 0, 0, 0);
        // zero required flow
        setup(8'd3, 32'd0, 32'd3);
        send(ACT_ADD, 1, 3, 30'd0);
        send(ACT_SOLVE, 0, 0, 0);

        for (int g = 0; g < 42; g++) begin
            quiet = (g >= 12 && g < 17);
            n = $urandom_range(0, 9) == 0 ? 8'($urandom_range(0, 1)) : 8'($urandom_range(2, 8));
            k = $urandom_range(0, 9);
            req = k == 0 ? $urandom : (k == 1 ? 32'd0 : $urandom_range(1, 6));
            k = $urandom_range(0, 9);
            cap = k == 0 ? $urandom : (k == 1 ? 32'd0 : $urandom_range(1, 3));
            setup(n, req, cap);
            k = $urandom_range(30, 60);
            repeat (k) send(ACT_ADD, pick_node(), pick_node(), pick_cost());
            send(ACT_SOLVE, $urandom_range(0, 255), $urandom_range(0, 255), 30'($urandom));
        end
        quiet = 0;

        drain();
        repeat (50) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("tb_min_cost_flow_bellman_ford: clean");
        end else begin
            $display("tb_min_cost_flow_bellman_ford: errors");
        end
        $finish;
    end

endmodule
`default_nettype wire
